FILE: design/multilevel_feedback_queue_scheduler_defines.svh
// Assertion macros shared by the scheduler RTL.
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_DEFINES_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MFQS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MFQS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/mfqs_pkg.sv
// Shared types and constants of the feedback queue scheduler.
package mfqs_pkg;

  localparam int PID_W     = 4;
  localparam int BURST_W   = 16;
  localparam int EV_W      = 3;
  localparam int LVL_W     = 3;
  localparam int TIME_W    = 32;
  localparam int QUANT_W   = 16;
  localparam int NUM_QREG  = 4;
  localparam int CFG_IDX_W = 2;
  localparam int PID_SPAN  = 1 << PID_W;

  // Command codes
  localparam logic CMD_ADMIT = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Result event codes
  localparam logic [EV_W-1:0] EV_ADMIT  = 3'd0;
  localparam logic [EV_W-1:0] EV_REJECT = 3'd1;
  localparam logic [EV_W-1:0] EV_IDLE   = 3'd2;
  localparam logic [EV_W-1:0] EV_RAN    = 3'd3;
  localparam logic [EV_W-1:0] EV_DONE   = 3'd4;
  localparam logic [EV_W-1:0] EV_DEMOTE = 3'd5;

  typedef struct packed {
    logic               cmd;
    logic [PID_W-1:0]   pid;
    logic [BURST_W-1:0] burst;
  } in_item_t;

  typedef struct packed {
    logic [EV_W-1:0]   event_res;
    logic [PID_W-1:0]  run_pid;
    logic [LVL_W-1:0]  run_level;
    logic [TIME_W-1:0] now;
  } out_item_t;

  // Default quantum of a level: reset value of the registered levels,
  // fixed limit of the others.
  function automatic logic [QUANT_W-1:0] quantum_default(input int lvl);
    return QUANT_W'(2 * lvl + 2);
  endfunction

endpackage

FILE: design/mfqs_ram.sv
// Simple dual-port RAM holding the ring buffers of all levels.
module mfqs_ram #(
  parameter int DEPTH = 80,
  parameter int AW    = 7,
  parameter int DW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/multilevel_feedback_queue_scheduler.sv
// Results: admit, reject and idle tick register their result in the execute state,
// an admit that rotates the last runner too; a tick that runs a process registers it in ST_TICK2.
// Throughput: a new item is accepted while the previous one executes, unless that is a tick that runs
// a process (registered ring read) or an admit that rotates the last runner (two ring writes); no receiver stall.
// Reset (rst_n low, synchronous) empties every level, clears all busy ids,
// zeroes the tick count and restores the quanta to 2, 4, 6 and 8.
`include "multilevel_feedback_queue_scheduler_defines.svh"

module multilevel_feedback_queue_scheduler #(
  parameter int LEVELS    = 5,
  parameter int MAX_PROCS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  mfqs_pkg::in_item_t                  in_data,
  output logic                                busy,
  output logic                                out_valid,
  output mfqs_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mfqs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mfqs_pkg::QUANT_W-1:0]        cfg_data
);
  import mfqs_pkg::*;

  localparam int LVW       = $clog2(LEVELS);
  localparam int SW        = $clog2(MAX_PROCS);
  localparam int CW        = $clog2(MAX_PROCS + 1);
  localparam int NSLOT     = (MAX_PROCS < PID_SPAN) ? MAX_PROCS : PID_SPAN;
  localparam int PW        = $clog2(NSLOT);
  localparam int AW        = LVW + SW;
  localparam int MEM_DEPTH = LEVELS << SW;
  localparam int TW        = $clog2(LEVELS * MAX_PROCS + 1);

  // Sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_TICK2 = 2'd2;
  localparam logic [1:0] ST_ROT   = 2'd3;

  logic [1:0]         state_r, state_nxt;
  in_item_t           in_r;
  logic [QUANT_W-1:0] quantum_r [NUM_QREG];
  logic [SW-1:0]      head_r [LEVELS];
  logic [SW-1:0]      head_nxt [LEVELS];
  logic [CW-1:0]      count_r [LEVELS];
  logic [CW-1:0]      count_nxt [LEVELS];
  logic [BURST_W-1:0] rem_r [NSLOT];
  logic [QUANT_W-1:0] used_r [NSLOT];
  logic [NSLOT-1:0]   pid_busy_r, pid_busy_nxt;
  logic               run_valid_r, run_valid_nxt;
  logic [LVW-1:0]     run_level_r, run_level_nxt;
  logic [PID_W-1:0]   run_pid_r, run_pid_nxt;
  logic [TIME_W-1:0]  time_r, time_nxt;
  logic [LVW-1:0]     tick_lvl_r;
  logic [AW-1:0]      rot_addr_r, rot_addr_nxt;
  logic [PID_W-1:0]   rot_pid_r;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  // Ring buffer port
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [PID_W-1:0]   mem_wdata, mem_rdata;

  // Per-process state write
  logic               proc_we;
  logic [PW-1:0]      proc_idx;
  logic [BURST_W-1:0] rem_wdata;
  logic [QUANT_W-1:0] used_wdata;

  logic               accept, long_op;
  logic               sel_found;
  logic [LVW-1:0]     sel_lvl;
  logic               pid_ok, adm_reject, rot;
  logic [PW-1:0]      pid_idx, p_idx;
  logic [SW-1:0]      tail0, rot_slot;
  logic [QUANT_W-1:0] q_lim, used_inc;
  logic [BURST_W-1:0] rem_cur;
  logic [QUANT_W-1:0] used_cur;
  logic [LVW-1:0]     next_lvl;
  logic               demote;
  logic [TW-1:0]      total_cnt;

  // Wrap a head+offset sum into the ring
  function automatic logic [SW-1:0] ring_wrap(input logic [SW:0] s);
    logic [SW:0] r;
    r = (s >= (SW+1)'(MAX_PROCS)) ? s - (SW+1)'(MAX_PROCS) : s;
    return r[SW-1:0];
  endfunction

  mfqs_ram #(
    .DEPTH (MEM_DEPTH),
    .AW    (AW),
    .DW    (PID_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Highest non-empty level
  always_comb begin
    sel_found = 1'b0;
    sel_lvl   = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (count_r[i] != '0) begin
        sel_found = 1'b1;
        sel_lvl   = LVW'(i);
      end
    end
  end

  // Admit checks and ring slots
  assign pid_ok     = int'(in_r.pid) < MAX_PROCS;
  assign pid_idx    = in_r.pid[PW-1:0];
  assign adm_reject = !pid_ok || pid_busy_r[pid_idx] || (count_r[0] >= CW'(MAX_PROCS));
  assign rot        = run_valid_r && (count_r[run_level_r] != '0);
  assign tail0      = ring_wrap((SW+1)'(head_r[0]) + (SW+1)'(count_r[0]));
  assign rot_slot   = (run_level_r == '0) ?
                      ring_wrap((SW+1)'(head_r[0]) + (SW+1)'(count_r[0]) + 1'b1) :
                      ring_wrap((SW+1)'(head_r[run_level_r]) +
                                (SW+1)'(count_r[run_level_r]));

  // Tick second half: process fetched from the ring
  assign p_idx    = mem_rdata[PW-1:0];
  assign rem_cur  = rem_r[p_idx];
  assign used_cur = used_r[p_idx];
  assign used_inc = (used_cur == '1) ? used_cur : used_cur + 1'b1;
  assign next_lvl = LVW'(tick_lvl_r + 1'b1);

  always_comb begin
    if (int'(tick_lvl_r) < NUM_QREG) begin
      q_lim = quantum_r[CFG_IDX_W'(tick_lvl_r)];
    end else begin
      q_lim = quantum_default(int'(tick_lvl_r));
    end
  end

  assign demote = (int'(tick_lvl_r) != LEVELS - 1) && (used_inc >= q_lim);

  // Handshake
  assign long_op = (state_r == ST_EXEC) &&
                   (((in_r.cmd == CMD_TICK) && sel_found) ||
                    ((in_r.cmd == CMD_ADMIT) && !adm_reject && rot));
  assign busy      = long_op;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Next-state and update logic
  always_comb begin
    state_nxt     = ST_IDLE;
    head_nxt      = head_r;
    count_nxt     = count_r;
    pid_busy_nxt  = pid_busy_r;
    run_valid_nxt = run_valid_r;
    run_level_nxt = run_level_r;
    run_pid_nxt   = run_pid_r;
    time_nxt      = time_r;
    rot_addr_nxt  = {run_level_r, rot_slot};
    out_valid_nxt = 1'b0;
    out_nxt       = '{event_res: EV_IDLE, run_pid: '0, run_level: '0, now: time_r};
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = in_r.pid;
    mem_re        = 1'b0;
    mem_raddr     = {sel_lvl, head_r[sel_lvl]};
    proc_we       = 1'b0;
    proc_idx      = pid_idx;
    rem_wdata     = in_r.burst;
    used_wdata    = '0;

    case (state_r)
      ST_EXEC: begin
        if (in_r.cmd == CMD_ADMIT) begin
          out_valid_nxt     = 1'b1;
          out_nxt.run_pid   = in_r.pid;
          out_nxt.event_res = EV_REJECT;
          if (!adm_reject) begin
            out_nxt.event_res     = EV_ADMIT;
            // Newcomer goes to the tail of level 0
            mem_we                = 1'b1;
            mem_waddr             = {LVW'(0), tail0};
            count_nxt[0]          = count_r[0] + 1'b1;
            pid_busy_nxt[pid_idx] = 1'b1;
            proc_we               = 1'b1;
            run_valid_nxt         = 1'b0;
            // Last runner leaves its head; written behind in ST_ROT
            if (rot) begin
              head_nxt[run_level_r] =
                ring_wrap((SW+1)'(head_r[run_level_r]) + 1'b1);
              state_nxt = ST_ROT;
            end
          end
        end else begin
          time_nxt = time_r + 1'b1;
          if (sel_found) begin
            mem_re    = 1'b1;
            state_nxt = ST_TICK2;
          end else begin
            run_valid_nxt = 1'b0;
            out_valid_nxt = 1'b1;
            out_nxt.now   = time_r + 1'b1;
          end
        end
      end

      ST_TICK2: begin
        out_valid_nxt     = 1'b1;
        out_nxt.run_pid   = mem_rdata;
        out_nxt.run_level = LVL_W'(tick_lvl_r);
        proc_we           = 1'b1;
        proc_idx          = p_idx;
        if (rem_cur <= BURST_W'(1)) begin
          // Completion
          out_nxt.event_res     = EV_DONE;
          rem_wdata             = '0;
          used_wdata            = used_cur;
          head_nxt[tick_lvl_r]  = ring_wrap((SW+1)'(head_r[tick_lvl_r]) + 1'b1);
          count_nxt[tick_lvl_r] = count_r[tick_lvl_r] - 1'b1;
          pid_busy_nxt[p_idx]   = 1'b0;
          run_valid_nxt         = 1'b0;
        end else if (demote) begin
          // Move to the tail of the next level down
          out_nxt.event_res     = EV_DEMOTE;
          rem_wdata             = rem_cur - 1'b1;
          used_wdata            = '0;
          head_nxt[tick_lvl_r]  = ring_wrap((SW+1)'(head_r[tick_lvl_r]) + 1'b1);
          count_nxt[tick_lvl_r] = count_r[tick_lvl_r] - 1'b1;
          count_nxt[next_lvl]   = count_r[next_lvl] + 1'b1;
          mem_we                = 1'b1;
          mem_waddr             = {next_lvl,
                                   ring_wrap((SW+1)'(head_r[next_lvl]) +
                                             (SW+1)'(count_r[next_lvl]))};
          mem_wdata             = mem_rdata;
          run_valid_nxt         = 1'b0;
        end else begin
          out_nxt.event_res = EV_RAN;
          rem_wdata         = rem_cur - 1'b1;
          used_wdata        = used_inc;
          run_valid_nxt     = 1'b1;
          run_level_nxt     = tick_lvl_r;
          run_pid_nxt       = mem_rdata;
        end
      end

      ST_ROT: begin
        mem_we    = 1'b1;
        mem_waddr = rot_addr_r;
        mem_wdata = rot_pid_r;
      end

      default: ;
    endcase

    if (accept) begin
      state_nxt = ST_EXEC;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '{default: '0};
      count_r     <= '{default: '0};
      pid_busy_r  <= '0;
      run_valid_r <= 1'b0;
      run_level_r <= '0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_QREG; i++) begin
        quantum_r[i] <= quantum_default(i);
      end
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      pid_busy_r  <= pid_busy_nxt;
      run_valid_r <= run_valid_nxt;
      run_level_r <= run_level_nxt;
      time_r      <= time_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        quantum_r[cfg_index] <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
    if (state_r == ST_EXEC) begin
      tick_lvl_r <= sel_lvl;
      rot_addr_r <= rot_addr_nxt;
      rot_pid_r  <= run_pid_r;
    end
    if (proc_we) begin
      rem_r[proc_idx]  <= rem_wdata;
      used_r[proc_idx] <= used_wdata;
    end
    run_pid_r <= run_pid_nxt;
    out_r     <= out_nxt;
  end

  // Occupancy across all levels
  always_comb begin
    total_cnt = '0;
    for (int i = 0; i < LEVELS; i++) begin
      total_cnt = total_cnt + TW'(count_r[i]);
    end
  end

  // Every scheduled id sits in exactly one level slot
  `MFQS_ASSERT_IMP(a_busy_matches_fill, 1'b1, $countones(pid_busy_r) == int'(total_cnt), "busy ids and level occupancy disagree")
  // The last runner is still queued in its level
  `MFQS_ASSERT_IMP(a_runner_queued, run_valid_r, count_r[run_level_r] != '0, "runner level is empty")
  // A fetched head always yields a result next cycle
  `MFQS_ASSERT_NXT(a_tick_result, state_r == ST_TICK2, out_valid_r, "tick gave no result")
  // Results only come from the execute or fetch steps
  `MFQS_ASSERT_IMP(a_result_source, out_valid_r, $past(state_r == ST_EXEC || state_r == ST_TICK2), "result from wrong step")

endmodule
